// ===== design/ccse_pkg.sv =====
// ----------------------------------------------------------------------------
// ccse_pkg
// Shared types, codes and calendar helpers for the clock set editor.
// ----------------------------------------------------------------------------
package ccse_pkg;

    // Field count and field positions in the calendar store
    localparam int NumFields  = 7;
    localparam int FieldW     = 7;
    localparam int FldYear    = 0;
    localparam int FldMonth   = 1;
    localparam int FldDay     = 2;
    localparam int FldHour    = 3;
    localparam int FldMinute  = 4;
    localparam int FldSecond  = 5;
    localparam int FldWeekday = 6;

    // Preset date and time after reset
    localparam logic [FieldW-1:0] PresetYear    = 7'd19;
    localparam logic [FieldW-1:0] PresetMonth   = 7'd11;
    localparam logic [FieldW-1:0] PresetDay     = 7'd16;
    localparam logic [FieldW-1:0] PresetHour    = 7'd12;
    localparam logic [FieldW-1:0] PresetMinute  = 7'd59;
    localparam logic [FieldW-1:0] PresetSecond  = 7'd55;
    localparam logic [FieldW-1:0] PresetWeekday = 7'd6;

    localparam logic [9:0] BlinkTicksReset = 10'd500;
    localparam logic [2:0] LastField       = 3'd6;

    // Operation codes of one input word
    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_MODE = 3'd1,
        OP_SEL  = 3'd2,
        OP_UP   = 3'd3,
        OP_DOWN = 3'd4,
        OP_LOAD = 3'd5
    } ccse_op_t;

    // Signed working value for one field during an adjust step
    typedef logic signed [8:0] ccse_wide_t;

    // One input word as held in the input register
    typedef struct packed {
        ccse_op_t   op;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
        logic [2:0] load_weekday;
    } ccse_item_t;

    // One result word
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
        logic       set_mode;
        logic [2:0] selected_field;
        logic       blink_on;
        logic       commit;
    } ccse_result_t;

    // Days in a month; zero for a month code outside 1..12
    function automatic logic [4:0] month_days(input ccse_wide_t yr, input ccse_wide_t mo);
        logic [4:0] d;
        if (mo == 9'sd2) begin
            d = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else if (mo == 9'sd4 || mo == 9'sd6 || mo == 9'sd9 || mo == 9'sd11) begin
            d = 5'd30;
        end else if (mo >= 9'sd1 && mo <= 9'sd12) begin
            d = 5'd31;
        end else begin
            d = 5'd0;
        end
        return d;
    endfunction

endpackage

// ===== design/ccse_in_stage.sv =====
// ----------------------------------------------------------------------------
// ccse_in_stage
// Input register: captures one word per cycle and holds it under back-pressure.
// ----------------------------------------------------------------------------
module ccse_in_stage
    import ccse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ccse_item_t in_item,
    output logic       item_valid,
    input  logic       item_ready,
    output ccse_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    ccse_item_t item_reg;

    // Stall only while a held word cannot move on
    assign in_stall   = valid_reg && !item_ready;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new word whenever the register is free or being emptied
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/ccse_edit.sv =====
// ----------------------------------------------------------------------------
// ccse_edit
// Editor state, per-word update logic and result register.
// ----------------------------------------------------------------------------
module ccse_edit
    import ccse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [9:0]   cfg_wr_data,
    input  logic         item_valid,
    output logic         item_ready,
    input  ccse_item_t   item,
    output logic         out_valid,
    input  logic         out_stall,
    output ccse_result_t result
);

    logic [FieldW-1:0] fld_reg  [NumFields];
    logic [FieldW-1:0] fld_next [NumFields];
    logic [FieldW-1:0] adj      [NumFields];
    ccse_wide_t        f_step   [NumFields];
    ccse_wide_t        f_wrap   [NumFields];
    logic [4:0]        lim;
    ccse_wide_t        lim_w;
    logic              down;

    logic              mode_reg, mode_next;
    logic [2:0]        sel_reg, sel_next;
    logic              blink_reg, blink_next;
    logic [9:0]        tick_reg, tick_next;
    logic [9:0]        tick_sum;
    logic [9:0]        blink_ticks_reg;
    logic              commit_next;
    logic              take;
    logic              out_valid_reg;
    ccse_result_t      result_reg;

    // Advance when the result register is free or being taken
    assign item_ready = !out_valid_reg || !out_stall;
    assign take       = item_valid && item_ready;
    assign down       = (item.op == OP_DOWN);

    // Step the selected field by one
    always_comb
    begin
        for (int i = 0; i < NumFields; i++)
        begin
            f_step[i] = $signed({2'b00, fld_reg[i]});
            if (3'(i) == sel_reg)
            begin
                f_step[i] = down ? f_step[i] - 9'sd1 : f_step[i] + 9'sd1;
            end
        end
    end

    // Wrap every field by the rules of the step direction
    always_comb
    begin
        for (int i = 0; i < NumFields; i++)
        begin
            f_wrap[i] = f_step[i];
        end
        lim   = 5'd0;
        lim_w = 9'sd0;
        if (!down)
        begin
            if (f_step[FldYear] > 9'sd99)  f_wrap[FldYear]  = 9'sd0;
            if (f_step[FldMonth] > 9'sd12) f_wrap[FldMonth] = 9'sd1;
            lim   = month_days(f_wrap[FldYear], f_wrap[FldMonth]);
            lim_w = $signed({4'b0000, lim});
            if (lim != 5'd0 && f_step[FldDay] > lim_w) f_wrap[FldDay] = 9'sd1;
            if (f_step[FldHour] > 9'sd23)    f_wrap[FldHour]    = 9'sd0;
            if (f_step[FldMinute] > 9'sd59)  f_wrap[FldMinute]  = 9'sd0;
            if (f_step[FldSecond] > 9'sd59)  f_wrap[FldSecond]  = 9'sd0;
            if (f_step[FldWeekday] > 9'sd7)  f_wrap[FldWeekday] = 9'sd1;
        end
        else
        begin
            if (f_step[FldYear] < 9'sd0)  f_wrap[FldYear]  = 9'sd99;
            if (f_step[FldMonth] < 9'sd1) f_wrap[FldMonth] = 9'sd12;
            lim   = month_days(f_wrap[FldYear], f_wrap[FldMonth]);
            lim_w = $signed({4'b0000, lim});
            if (lim != 5'd0)
            begin
                if (f_step[FldDay] < 9'sd1)
                begin
                    f_wrap[FldDay] = lim_w;
                end
                else if (lim != 5'd31 && f_step[FldDay] > lim_w)
                begin
                    f_wrap[FldDay] = 9'sd1;
                end
            end
            if (f_step[FldHour] < 9'sd0)    f_wrap[FldHour]    = 9'sd23;
            if (f_step[FldMinute] < 9'sd0)  f_wrap[FldMinute]  = 9'sd59;
            if (f_step[FldSecond] < 9'sd0)  f_wrap[FldSecond]  = 9'sd59;
            if (f_step[FldWeekday] < 9'sd1) f_wrap[FldWeekday] = 9'sd7;
        end
        for (int i = 0; i < NumFields; i++)
        begin
            adj[i] = f_wrap[i][FieldW-1:0];
        end
    end

    assign tick_sum = tick_reg + 10'd1;

    // Next state for one accepted word
    always_comb
    begin
        for (int i = 0; i < NumFields; i++)
        begin
            fld_next[i] = fld_reg[i];
        end
        mode_next   = mode_reg;
        sel_next    = sel_reg;
        blink_next  = blink_reg;
        tick_next   = tick_reg;
        commit_next = 1'b0;
        if (take)
        begin
            case (item.op)
                OP_TICK:
                begin
                    if (tick_sum >= blink_ticks_reg)
                    begin
                        tick_next  = 10'd0;
                        blink_next = !blink_reg;
                    end
                    else
                    begin
                        tick_next = tick_sum;
                    end
                end
                OP_MODE:
                begin
                    if (!mode_reg)
                    begin
                        mode_next  = 1'b1;
                        blink_next = 1'b0;
                    end
                    else
                    begin
                        mode_next   = 1'b0;
                        commit_next = 1'b1;
                    end
                end
                OP_SEL:
                begin
                    if (mode_reg)
                    begin
                        sel_next = (sel_reg == LastField) ? 3'd0 : sel_reg + 3'd1;
                    end
                end
                OP_UP, OP_DOWN:
                begin
                    if (mode_reg)
                    begin
                        for (int i = 0; i < NumFields; i++)
                        begin
                            fld_next[i] = adj[i];
                        end
                    end
                end
                OP_LOAD:
                begin
                    if (!mode_reg)
                    begin
                        fld_next[FldYear]    = item.load_year;
                        fld_next[FldMonth]   = {3'b000, item.load_month};
                        fld_next[FldDay]     = {2'b00, item.load_day};
                        fld_next[FldHour]    = {2'b00, item.load_hour};
                        fld_next[FldMinute]  = {1'b0, item.load_minute};
                        fld_next[FldSecond]  = {1'b0, item.load_second};
                        fld_next[FldWeekday] = {4'b0000, item.load_weekday};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold editor state and the blink limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_reg[FldYear]    <= PresetYear;
            fld_reg[FldMonth]   <= PresetMonth;
            fld_reg[FldDay]     <= PresetDay;
            fld_reg[FldHour]    <= PresetHour;
            fld_reg[FldMinute]  <= PresetMinute;
            fld_reg[FldSecond]  <= PresetSecond;
            fld_reg[FldWeekday] <= PresetWeekday;
            mode_reg        <= 1'b0;
            sel_reg         <= 3'd0;
            blink_reg       <= 1'b0;
            tick_reg        <= 10'd0;
            blink_ticks_reg <= BlinkTicksReset;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NumFields; i++)
            begin
                fld_reg[i] <= fld_next[i];
            end
            mode_reg  <= mode_next;
            sel_reg   <= sel_next;
            blink_reg <= blink_next;
            tick_reg  <= tick_next;
            if (cfg_wr_en)
            begin
                blink_ticks_reg <= cfg_wr_data;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    // Load the result word on every accepted input word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.year           <= fld_next[FldYear];
            result_reg.month          <= fld_next[FldMonth][3:0];
            result_reg.day            <= fld_next[FldDay][4:0];
            result_reg.hour           <= fld_next[FldHour][4:0];
            result_reg.minute         <= fld_next[FldMinute][5:0];
            result_reg.second         <= fld_next[FldSecond][5:0];
            result_reg.weekday        <= fld_next[FldWeekday][2:0];
            result_reg.set_mode       <= mode_next;
            result_reg.selected_field <= sel_next;
            result_reg.blink_on       <= blink_next;
            result_reg.commit         <= commit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== design/clock_calendar_set_editor.sv =====
// ----------------------------------------------------------------------------
// clock_calendar_set_editor
// Time-set controller for a calendar clock: keys, ticks and chip loads in,
// calendar fields, mode, selection, blink and commit out.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_stall     op, load_year .. load_weekday
//  result    out_valid / out_stall   year .. weekday, set_mode,
//                                    selected_field, blink_on, commit
//  config    cfg_wr_en               cfg_wr_data (blink_ticks)
//
// Every input word gives one result word on the ports: the input register
// captures it when it is accepted and the update logic loads the result
// register when it takes the word from the input register. One word is
// accepted per cycle while the result side keeps up.
// Reset loads the preset date and time, show mode, field 0 and a limit of 500.
// A stall on the result side holds the result and stalls the input register.
// ----------------------------------------------------------------------------
module clock_calendar_set_editor
    import ccse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] op,
    input  logic [6:0] load_year,
    input  logic [3:0] load_month,
    input  logic [4:0] load_day,
    input  logic [4:0] load_hour,
    input  logic [5:0] load_minute,
    input  logic [5:0] load_second,
    input  logic [2:0] load_weekday,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] year,
    output logic [3:0] month,
    output logic [4:0] day,
    output logic [4:0] hour,
    output logic [5:0] minute,
    output logic [5:0] second,
    output logic [2:0] weekday,
    output logic       set_mode,
    output logic [2:0] selected_field,
    output logic       blink_on,
    output logic       commit
);

    ccse_item_t   in_item;
    ccse_item_t   item;
    logic         item_valid;
    logic         item_ready;
    ccse_result_t result;

    // Pack the input word
    always_comb
    begin
        in_item.op           = ccse_op_t'(op);
        in_item.load_year    = load_year;
        in_item.load_month   = load_month;
        in_item.load_day     = load_day;
        in_item.load_hour    = load_hour;
        in_item.load_minute  = load_minute;
        in_item.load_second  = load_second;
        in_item.load_weekday = load_weekday;
    end

    ccse_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    ccse_edit u_edit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    // Unpack the result word
    assign year           = result.year;
    assign month          = result.month;
    assign day            = result.day;
    assign hour           = result.hour;
    assign minute         = result.minute;
    assign second         = result.second;
    assign weekday        = result.weekday;
    assign set_mode       = result.set_mode;
    assign selected_field = result.selected_field;
    assign blink_on       = result.blink_on;
    assign commit         = result.commit;

endmodule
